>>> src/fssm_pkg.sv
// Package for the first substring match search block.
// Holds shared constants, register indexes and the configuration struct.
// No dependencies.
`default_nettype none

package fssm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 16;

    // Configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Fixed register widths
    localparam int PATTERN_W = 128;
    localparam int LEN_W     = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Pattern as seen by the datapath; length is already clamped
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [LEN_W-1:0]     length;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/fssm_if.sv
// Stream channel interfaces for the first substring match search block.
// Depends on fssm_pkg for the default offset width.
`default_nettype none

interface fssm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] haystack_byte;
    logic       last_byte;

    modport source (output valid, output haystack_byte, output last_byte, input ready);
    modport sink   (input valid, input haystack_byte, input last_byte, output ready);
endinterface

interface fssm_out_if #(
    parameter int OFFSET_WIDTH = fssm_pkg::OFFSET_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [OFFSET_WIDTH-1:0] match_offset;
    logic                    too_long;

    modport source (output valid, output found, output match_offset, output too_long,
                    input ready);
    modport sink   (input valid, input found, input match_offset, input too_long,
                    output ready);
endinterface

`default_nettype wire

>>> src/fssm_cfg_regs.sv
// Configuration registers of the first substring match search block.
// Depends on fssm_pkg; hands the pattern and clamped length out as cfg_t.
`default_nettype none

module fssm_cfg_regs #(
    parameter int MAX_PATTERN = fssm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [fssm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fssm_pkg::CFG_DATA_W-1:0] cfg_data,
    output fssm_pkg::cfg_t                      cfg
);
    import fssm_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp the length to the supported pattern size
    always_comb
    begin
        cfg.pattern = {pattern_high_reg, pattern_low_reg};
        cfg.length  = (pattern_length_reg > MAX_LEN) ? MAX_LEN : pattern_length_reg;
    end

endmodule

`default_nettype wire

>>> src/fssm_match.sv
// Window compare of the first substring match search block.
// Depends on fssm_pkg; checks the window plus the current byte against the pattern.
`default_nettype none

module fssm_match #(
    parameter int MAX_PATTERN = fssm_pkg::MAX_PATTERN_DEF,
    parameter int WIN_DEPTH   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
    input  wire fssm_pkg::cfg_t cfg,
    input  wire logic [7:0]     window [WIN_DEPTH],
    input  wire logic [7:0]     cur_byte,
    output logic                hit
);
    import fssm_pkg::*;

    logic cand;

    // Evaluate every candidate length, keep the one configured
    always_comb
    begin
        hit  = 1'b0;
        cand = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            cand = (cfg.pattern[8*(l-1) +: 8] == cur_byte);
            for (int k = 0; k < l - 1; k++)
            begin
                if (window[l-2-k] != cfg.pattern[8*k +: 8])
                begin
                    cand = 1'b0;
                end
            end
            if (cfg.length == LEN_W'(l))
            begin
                hit = cand;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/first_substring_match_search_top.sv
// Top level of the first substring match search block.
// Depends on fssm_pkg, fssm_if, fssm_cfg_regs and fssm_match.
//
// Usage:
//   The haystack channel takes one text byte per item, with last_byte set on
//   the final byte of each haystack. The result channel gives one item per
//   haystack: found, match_offset of the first match start, and too_long.
//   The pattern is loaded through the write port (low word, high word,
//   length) while no haystack is in flight.
// Order and rate:
//   An item is taken into the input register, compared against the pattern in
//   the next cycle, and its result loads into the result register as its last
//   byte leaves. One byte is taken every cycle unless a final byte waits on a
//   result not yet taken; the compare between both registers is combinational.
// Reset:
//   Clears the pattern registers, the byte window, count and match record,
//   and drops any pending item or result.
// Stall:
//   While a result waits, non-final bytes keep flowing; the haystack channel
//   holds ready low only when a final byte meets a result not yet taken.
`default_nettype none

module first_substring_match_search_top #(
    parameter int MAX_PATTERN  = fssm_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_WIDTH = fssm_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    fssm_in_if.sink                              haystack,
    fssm_out_if.source                           result,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fssm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fssm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fssm_pkg::*;

    localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int CNT_W     = OFFSET_WIDTH + 1;

    cfg_t cfg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    logic [7:0]              window_reg [WIN_DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic                    seen_reg;
    logic [OFFSET_WIDTH-1:0] first_reg;

    logic                    out_valid_reg;
    logic                    found_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic                    too_long_reg;

    logic                    hit;
    logic                    out_free;
    logic                    s1_fire;
    logic                    in_take;
    logic [CNT_W:0]          pos_plus1;
    logic                    detect;
    logic [CNT_W:0]          offset_wide;
    logic                    seen_next;
    logic [OFFSET_WIDTH-1:0] first_next;
    logic [CNT_W-1:0]        count_next;
    logic                    emit;
    logic                    found_next;
    logic [OFFSET_WIDTH-1:0] offset_next;
    logic                    too_long_next;

    fssm_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fssm_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .WIN_DEPTH   (WIN_DEPTH)
    ) u_match (
        .cfg      (cfg),
        .window   (window_reg),
        .cur_byte (s1_byte_reg),
        .hit      (hit)
    );

    // Handshake: only a final byte waits for the result register
    assign out_free       = !out_valid_reg || result.ready;
    assign s1_fire        = s1_valid_reg && (!s1_last_reg || out_free);
    assign haystack.ready = !s1_valid_reg || s1_fire;
    assign in_take        = haystack.valid && haystack.ready;

    // Match record, byte count and result for the item in the input register
    always_comb
    begin
        pos_plus1   = {1'b0, count_reg} + (CNT_W+1)'(1);
        detect      = (cfg.length != '0) && !seen_reg && !count_reg[OFFSET_WIDTH]
                      && (pos_plus1 >= (CNT_W+1)'(cfg.length)) && hit;
        offset_wide = pos_plus1 - (CNT_W+1)'(cfg.length);
        seen_next   = seen_reg || detect;
        first_next  = detect ? offset_wide[OFFSET_WIDTH-1:0] : first_reg;

        // Saturate one past the indexable length
        if (count_reg[OFFSET_WIDTH] && (count_reg[OFFSET_WIDTH-1:0] != '0))
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
        end

        too_long_next = count_next[OFFSET_WIDTH] && (count_next[OFFSET_WIDTH-1:0] != '0);
        emit          = s1_fire && s1_last_reg;

        if (cfg.length == '0)
        begin
            found_next  = 1'b1;
            offset_next = '0;
        end
        else
        begin
            found_next  = seen_next;
            offset_next = seen_next ? first_next : '0;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (haystack.ready)
        begin
            s1_valid_reg <= haystack.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= haystack.haystack_byte;
            s1_last_reg <= haystack.last_byte;
        end
    end

    // Search state: advance on each byte, clear after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            count_reg <= '0;
            seen_reg  <= 1'b0;
            first_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= '0;
                end
                count_reg <= '0;
                seen_reg  <= 1'b0;
                first_reg <= '0;
            end
            else
            begin
                window_reg[0] <= s1_byte_reg;
                for (int i = 1; i < WIN_DEPTH; i++)
                begin
                    window_reg[i] <= window_reg[i-1];
                end
                count_reg <= count_next;
                seen_reg  <= seen_next;
                first_reg <= first_next;
            end
        end
    end

    // Result register valid: load on a final byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg    <= found_next;
            offset_reg   <= offset_next;
            too_long_reg <= too_long_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.match_offset = offset_reg;
    assign result.too_long     = too_long_reg;

endmodule

`default_nettype wire

>>> src/fssm_checker.sv
// Port-level checks for the first substring match search block.
// Bound to first_substring_match_search_top; depends on nothing else.
`default_nettype none

module fssm_checker #(
    parameter int OFFSET_WIDTH = 16
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic                    out_found,
    input wire logic [OFFSET_WIDTH-1:0] out_offset,
    input wire logic                    out_too_long
);

    // A pending result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // A stalled result holds its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_found) && $stable(out_offset)
                                    && $stable(out_too_long))
        else $error("stalled result changed");

    // Input stalls only behind a result the receiver holds off
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A miss reports offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_offset == '0)
        else $error("nonzero offset on a miss");

endmodule

bind first_substring_match_search_top fssm_checker #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
) u_fssm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (haystack.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_found    (result.found),
    .out_offset   (result.match_offset),
    .out_too_long (result.too_long)
);

`default_nettype wire
